// ===== sv/gbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gbpf_pkg
// Shared widths, register codes and payload types for the stereo band filter.
// ----------------------------------------------------------------------------
package gbpf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int STATE_BITS  = 32;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int STATE_FRAC  = STATE_BITS - 8;
    // binary point shift between sample and state formats
    localparam int POINT_SHIFT = STATE_FRAC - SAMPLE_FRAC;

    localparam int COEF_BITS   = 17;
    localparam int GLIDE_BITS  = 9;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    localparam int CHANNELS    = 2;
    localparam int STAGES      = 6;
    localparam int ENTRIES     = CHANNELS * STAGES;
    localparam int ENTRY_BITS  = $clog2(ENTRIES);

    localparam logic [COEF_BITS-1:0] UNITY = COEF_BITS'(65536);

    // register indexes, byte address = 4 * index
    localparam logic [2:0] REG_LOWPASS_TARGET  = 3'd0;
    localparam logic [2:0] REG_HIGHPASS_TARGET = 3'd1;
    localparam logic [2:0] REG_WET_TARGET      = 3'd2;
    localparam logic [2:0] REG_LOWPASS_GLIDE   = 3'd3;
    localparam logic [2:0] REG_HIGHPASS_GLIDE  = 3'd4;
    localparam logic [2:0] REG_WET_GLIDE       = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } frame_out_t;

endpackage

// ===== sv/gearbox_bandpass_filter_stereo.sv =====
// ----------------------------------------------------------------------------
// gearbox_bandpass_filter_stereo
// Stereo three-pair highpass/lowpass cascade with rotating stages, gliding
// coefficients and a saturated dry/wet mix.
// ----------------------------------------------------------------------------
// A new frame is taken only in the idle state, so frames do not overlap; the
//   frame rate is set by the single shared multiplier and the read-modify-write
//   of the filter state memory: each stage pair steps through RD, MH, AH, XL,
//   ML and AL, three pairs and the MW/AW mix run per channel after the glide
//   steps, and DONE loads the output register, waiting while it is still full.
// Reset: asynchronous, active low. Config returns to its defaults, live
//   coefficients and phase clear, and the state memory reads as zero through
//   per-entry valid bits (no clearing pass).
// ----------------------------------------------------------------------------
module gearbox_bandpass_filter_stereo (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbpf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [gbpf_pkg::DATA_BITS-1:0] pwdata,
    output logic [gbpf_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    // frame in
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  gbpf_pkg::frame_in_t           sample_data,
    // frame out
    output logic                          result_valid,
    input  logic                          result_ready,
    output gbpf_pkg::frame_out_t          result_data
);
    import gbpf_pkg::*;

    localparam int DIFF_BITS = STATE_BITS + 1;
    localparam int MULB_BITS = COEF_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + MULB_BITS;
    localparam int SHR_BITS  = PROD_BITS - 16;
    localparam int ACC_BITS  = STATE_BITS + 4;
    localparam int MEM_BITS  = 2 * STATE_BITS;

    // Sequencer. One stage pair is RD (memory read), MH (highpass multiply),
    // AH (highpass update), XL (subtract track), ML (lowpass multiply),
    // AL (lowpass update and write back). MW/AW do the wet mix.
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_GLIDE = 11'b000_0000_0010,
        ST_RD    = 11'b000_0000_0100,
        ST_MH    = 11'b000_0000_1000,
        ST_AH    = 11'b000_0001_0000,
        ST_XL    = 11'b000_0010_0000,
        ST_ML    = 11'b000_0100_0000,
        ST_AL    = 11'b000_1000_0000,
        ST_MW    = 11'b001_0000_0000,
        ST_AW    = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } seq_state_t;

    // ---------------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------------
    function automatic logic [STATE_BITS-1:0] sat_state(input logic [ACC_BITS-1:0] v);
        logic [ACC_BITS-STATE_BITS:0] top;
        top = v[ACC_BITS-1:STATE_BITS-1];
        if ((&top) || !(|top))
            return v[STATE_BITS-1:0];
        else if (v[ACC_BITS-1])
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            return {1'b0, {(STATE_BITS-1){1'b1}}};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [STATE_BITS-1:0] v);
        logic [STATE_BITS-SAMPLE_BITS:0] top;
        top = v[STATE_BITS-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            return v[SAMPLE_BITS-1:0];
        else if (v[STATE_BITS-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    function automatic logic [ACC_BITS-1:0] ext_state(input logic [STATE_BITS-1:0] v);
        return {{(ACC_BITS-STATE_BITS){v[STATE_BITS-1]}}, v};
    endfunction

    // sample format to state format: move the binary point
    function automatic logic [STATE_BITS-1:0] to_state(input logic [SAMPLE_BITS-1:0] s);
        return {{(STATE_BITS-SAMPLE_BITS-POINT_SHIFT){s[SAMPLE_BITS-1]}}, s,
                {POINT_SHIFT{1'b0}}};
    endfunction

    // glide one step, rounded up so the target is met exactly
    function automatic logic [COEF_BITS-1:0] glide_next(input logic [COEF_BITS-1:0] now,
                                                        input logic [COEF_BITS-1:0] tgt,
                                                        input logic [GLIDE_BITS-1:0] g);
        logic [COEF_BITS-1:0]            t;
        logic [COEF_BITS-1:0]            mag;
        logic [COEF_BITS-1:0]            step;
        logic [COEF_BITS+GLIDE_BITS:0]   prod;
        logic [COEF_BITS+GLIDE_BITS-16:0] up;
        t    = (tgt > UNITY) ? UNITY : tgt;
        mag  = (t > now) ? (t - now) : (now - t);
        prod = {{(GLIDE_BITS+1){1'b0}}, mag} * {{(COEF_BITS+1){1'b0}}, g}
             + (COEF_BITS+GLIDE_BITS+1)'(65535);
        up   = prod[COEF_BITS+GLIDE_BITS:16];
        step = ({{(COEF_BITS-$bits(up)){1'b0}}, up} > mag) ? mag
             : {{(COEF_BITS-$bits(up)){1'b0}}, up};
        return (t > now) ? (now + step) : (now - step);
    endfunction

    // stage slot within a channel: A, then B/C by parity, then D/E/F by mod 3
    function automatic logic [2:0] stage_slot(input logic [2:0] phase,
                                              input logic [1:0] stg);
        logic [2:0] m3;
        case (phase)
            3'd0, 3'd3: m3 = 3'd0;
            3'd1, 3'd4: m3 = 3'd1;
            3'd2, 3'd5: m3 = 3'd2;
            default:    m3 = 3'd0;
        endcase
        case (stg)
            2'd0:    return 3'd0;
            2'd1:    return phase[0] ? 3'd2 : 3'd1;
            default: return 3'd3 + m3;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [COEF_BITS-1:0]  lp_tgt_reg, hp_tgt_reg, wet_tgt_reg;
    logic [GLIDE_BITS-1:0] lp_gl_reg, hp_gl_reg, wet_gl_reg;
    logic [2:0]            reg_idx;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_tgt_reg  <= UNITY;
            hp_tgt_reg  <= '0;
            wet_tgt_reg <= UNITY;
            lp_gl_reg   <= GLIDE_BITS'(218);
            hp_gl_reg   <= GLIDE_BITS'(218);
            wet_gl_reg  <= GLIDE_BITS'(218);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_LOWPASS_TARGET:  lp_tgt_reg  <= pwdata[COEF_BITS-1:0];
                REG_HIGHPASS_TARGET: hp_tgt_reg  <= pwdata[COEF_BITS-1:0];
                REG_WET_TARGET:      wet_tgt_reg <= pwdata[COEF_BITS-1:0];
                REG_LOWPASS_GLIDE:   lp_gl_reg   <= pwdata[GLIDE_BITS-1:0];
                REG_HIGHPASS_GLIDE:  hp_gl_reg   <= pwdata[GLIDE_BITS-1:0];
                REG_WET_GLIDE:       wet_gl_reg  <= pwdata[GLIDE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LOWPASS_TARGET:  prdata = {{(DATA_BITS-COEF_BITS){1'b0}}, lp_tgt_reg};
            REG_HIGHPASS_TARGET: prdata = {{(DATA_BITS-COEF_BITS){1'b0}}, hp_tgt_reg};
            REG_WET_TARGET:      prdata = {{(DATA_BITS-COEF_BITS){1'b0}}, wet_tgt_reg};
            REG_LOWPASS_GLIDE:   prdata = {{(DATA_BITS-GLIDE_BITS){1'b0}}, lp_gl_reg};
            REG_HIGHPASS_GLIDE:  prdata = {{(DATA_BITS-GLIDE_BITS){1'b0}}, hp_gl_reg};
            REG_WET_GLIDE:       prdata = {{(DATA_BITS-GLIDE_BITS){1'b0}}, wet_gl_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // control and datapath registers
    // ---------------------------------------------------------------------
    seq_state_t            state_reg, state_next;
    logic [2:0]            phase_reg, phase_next;
    logic [COEF_BITS-1:0]  lp_now_reg, lp_now_next;
    logic [COEF_BITS-1:0]  hp_now_reg, hp_now_next;
    logic [COEF_BITS-1:0]  wet_now_reg, wet_now_next;
    logic [1:0]            gcnt_reg, gcnt_next;   // which coefficient glides
    logic                  ch_reg, ch_next;       // 0 left, 1 right
    logic [1:0]            stg_reg, stg_next;     // pair within the cascade
    logic                  rv_reg, rv_next;       // result valid
    logic [ENTRIES-1:0]    valid_reg, valid_next; // entry written since reset

    frame_in_t             in_reg, in_next;
    logic [STATE_BITS-1:0] x_reg, x_next;         // signal moving down the cascade
    logic [STATE_BITS-1:0] dry_reg, dry_next;
    logic [STATE_BITS-1:0] hpn_reg, hpn_next;     // updated highpass track
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0] left_reg, left_next;
    logic [SAMPLE_BITS-1:0] right_reg, right_next;
    frame_out_t            res_reg, res_next;

    // state memory: {highpass, lowpass} per entry, entry = channel*6 + stage
    logic [MEM_BITS-1:0]   filt_mem [ENTRIES];
    logic [MEM_BITS-1:0]   mem_q_reg;
    logic                  vld_q_reg;
    logic [ENTRY_BITS-1:0] mem_addr;
    logic                  mem_rd, mem_wr;
    logic [MEM_BITS-1:0]   mem_wdata;

    // datapath nets
    logic [STATE_BITS-1:0] hp_old, lp_old;
    logic [STATE_BITS-1:0] mul_x, mul_base, acc_base;
    logic signed [DIFF_BITS-1:0] mul_a;
    logic signed [MULB_BITS-1:0] mul_b;
    logic signed [PROD_BITS-1:0] mul_p;
    logic [COEF_BITS-1:0]  mul_coef;
    logic [ACC_BITS-1:0]   acc_sum;
    logic [STATE_BITS-1:0] acc_sat;
    logic [STATE_BITS-1:0] x_sub;
    logic [STATE_BITS-1:0] to_smp;
    logic [SAMPLE_BITS-1:0] out_smp;

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = rv_reg;
    assign result_data  = res_reg;

    assign mem_addr = (ch_reg ? ENTRY_BITS'(STAGES) : ENTRY_BITS'(0))
                    + ENTRY_BITS'(stage_slot(phase_reg, stg_reg));
    assign mem_rd    = (state_reg == ST_RD);
    assign mem_wr    = (state_reg == ST_AL);
    assign mem_wdata = {hpn_reg, acc_sat};

    // an entry never written since reset reads as zero
    assign hp_old = vld_q_reg ? mem_q_reg[MEM_BITS-1:STATE_BITS] : '0;
    assign lp_old = vld_q_reg ? mem_q_reg[STATE_BITS-1:0]        : '0;

    // shared multiplier operands: (x - track) * coefficient
    always_comb
    begin
        case (state_reg)
            ST_MH:
            begin
                mul_base = hp_old;
                mul_coef = hp_now_reg;
            end
            ST_ML:
            begin
                mul_base = lp_old;
                mul_coef = lp_now_reg;
            end
            default:
            begin
                mul_base = dry_reg;
                mul_coef = wet_now_reg;
            end
        endcase
    end
    assign mul_x = x_reg;
    assign mul_a = $signed({mul_x[STATE_BITS-1], mul_x})
                 - $signed({mul_base[STATE_BITS-1], mul_base});
    assign mul_b = $signed({1'b0, mul_coef});
    // full-width signed product
    assign mul_p = mul_a * mul_b;

    // track update: base + floor(product / 65536), saturated
    always_comb
    begin
        case (state_reg)
            ST_AH:   acc_base = hp_old;
            ST_AL:   acc_base = lp_old;
            default: acc_base = dry_reg;
        endcase
    end
    assign acc_sum = ext_state(acc_base)
                   + {{(ACC_BITS-SHR_BITS){prod_reg[PROD_BITS-1]}},
                      prod_reg[PROD_BITS-1:16]};
    assign acc_sat = sat_state(acc_sum);

    // subtract the highpass track from the stage input
    assign x_sub = sat_state(ext_state(x_reg) - ext_state(hpn_reg));

    // back to sample format, floor, then clamp
    assign to_smp  = STATE_BITS'($signed(acc_sat) >>> POINT_SHIFT);
    assign out_smp = sat_sample(to_smp);

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            filt_mem[mem_addr] <= mem_wdata;
        if (mem_rd)
            mem_q_reg <= filt_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_q_reg <= 1'b0;
        else if (mem_rd)
            vld_q_reg <= valid_reg[mem_addr];
    end

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        lp_now_next  = lp_now_reg;
        hp_now_next  = hp_now_reg;
        wet_now_next = wet_now_reg;
        gcnt_next    = gcnt_reg;
        ch_next      = ch_reg;
        stg_next     = stg_reg;
        rv_next      = rv_reg && !result_ready;
        valid_next   = valid_reg;
        in_next      = in_reg;
        x_next       = x_reg;
        dry_next     = dry_reg;
        hpn_next     = hpn_reg;
        prod_next    = prod_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        res_next     = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    in_next    = sample_data;
                    // phase steps before filtering
                    phase_next = (phase_reg >= 3'd5) ? 3'd0 : phase_reg + 3'd1;
                    gcnt_next  = 2'd0;
                    state_next = ST_GLIDE;
                end
            end
            ST_GLIDE:
            begin
                case (gcnt_reg)
                    2'd0:    lp_now_next  = glide_next(lp_now_reg, lp_tgt_reg, lp_gl_reg);
                    2'd1:    hp_now_next  = glide_next(hp_now_reg, hp_tgt_reg, hp_gl_reg);
                    default: wet_now_next = glide_next(wet_now_reg, wet_tgt_reg, wet_gl_reg);
                endcase
                gcnt_next = gcnt_reg + 2'd1;
                if (gcnt_reg == 2'd2)
                begin
                    dry_next   = to_state(in_reg.left_sample);
                    x_next     = to_state(in_reg.left_sample);
                    ch_next    = 1'b0;
                    stg_next   = 2'd0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
                state_next = ST_MH;
            ST_MH:
            begin
                prod_next  = mul_p;
                state_next = ST_AH;
            end
            ST_AH:
            begin
                hpn_next   = acc_sat;
                state_next = ST_XL;
            end
            ST_XL:
            begin
                x_next     = x_sub;
                state_next = ST_ML;
            end
            ST_ML:
            begin
                prod_next  = mul_p;
                state_next = ST_AL;
            end
            ST_AL:
            begin
                valid_next[mem_addr] = 1'b1;
                x_next = acc_sat;
                if (stg_reg == 2'd2)
                    state_next = ST_MW;
                else
                begin
                    stg_next   = stg_reg + 2'd1;
                    state_next = ST_RD;
                end
            end
            ST_MW:
            begin
                prod_next  = mul_p;
                state_next = ST_AW;
            end
            ST_AW:
            begin
                if (!ch_reg)
                begin
                    left_next  = out_smp;
                    dry_next   = to_state(in_reg.right_sample);
                    x_next     = to_state(in_reg.right_sample);
                    ch_next    = 1'b1;
                    stg_next   = 2'd0;
                    state_next = ST_RD;
                end
                else
                begin
                    right_next = out_smp;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!rv_reg || result_ready)
                begin
                    res_next.left_out  = left_reg;
                    res_next.right_out = right_reg;
                    rv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            lp_now_reg  <= '0;
            hp_now_reg  <= '0;
            wet_now_reg <= '0;
            gcnt_reg    <= '0;
            ch_reg      <= 1'b0;
            stg_reg     <= '0;
            rv_reg      <= 1'b0;
            valid_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            lp_now_reg  <= lp_now_next;
            hp_now_reg  <= hp_now_next;
            wet_now_reg <= wet_now_next;
            gcnt_reg    <= gcnt_next;
            ch_reg      <= ch_next;
            stg_reg     <= stg_next;
            rv_reg      <= rv_next;
            valid_reg   <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        x_reg     <= x_next;
        dry_reg   <= dry_next;
        hpn_reg   <= hpn_next;
        prod_reg  <= prod_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        res_reg   <= res_next;
    end

endmodule
